FILE: sv/itoa_pkg.sv
// Shared constants, types and helpers for the integer to radix ASCII block.
// No dependencies; compile first.
package itoa_pkg;

  localparam int VALUE_WIDTH_DEF = 64;  // default converted width
  localparam int VALUE_PORT_W    = 64;  // width of the value field
  localparam int RADIX_W         = 5;
  localparam int DIGIT_W         = 4;
  localparam int DIGIT_DEPTH     = 64;
  localparam int COUNT_W         = 7;
  localparam int CHAR_W          = 8;

  localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;
  localparam logic [RADIX_W-1:0] DEC_RADIX = 5'd10;
  localparam logic [RADIX_W-1:0] HEX_RADIX = 5'd16;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_ALPHA = 8'h57;  // 'a' - 10
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;  // '-'

  // Divider control from the sequencer.
  typedef struct packed {
    logic                 start;  // begin one digit pass
    logic                 load;   // with start: take a new value and radix
    logic [RADIX_W-1:0]   radix;
  } div_ctl_t;

  // Divider status back to the sequencer.
  typedef struct packed {
    logic                 done;   // one-cycle pulse, digit and q_nz valid
    logic                 q_nz;   // quotient left after this pass is nonzero
    logic [DIGIT_W-1:0]   digit;
  } div_sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) c = CHAR_ZERO + CHAR_W'(d);
    else           c = CHAR_ALPHA + CHAR_W'(d);
    return c;
  endfunction

endpackage

FILE: sv/itoa_if.sv
// Valid/ready channel interfaces for the input numbers and output characters.
// Depends on itoa_pkg.
interface itoa_in_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic [itoa_pkg::RADIX_W-1:0]        radix;
  logic [itoa_pkg::VALUE_PORT_W-1:0]   value;

  modport source (output valid, operation, radix, value, input ready);
  modport sink   (input valid, operation, radix, value, output ready);
endinterface

interface itoa_out_if;
  logic                                valid;
  logic                                ready;
  logic [itoa_pkg::CHAR_W-1:0]         character;
  logic                                last;

  modport source (output valid, character, last, input ready);
  modport sink   (input valid, character, last, output ready);
endinterface

FILE: sv/integer_to_radix_ascii.sv
// Top level of the integer to radix ASCII converter: sequencer, digit RAM and
// character output register. Depends on itoa_pkg, itoa_if, itoa_ram, itoa_divider.
//
// Takes one number at a time on in_ch (value, radix 2..16, signed or unsigned
// operation) and returns its ASCII digits on out_ch, most significant first,
// lower-case letters, last set on the final character. Zero gives "0". A
// negative signed number gives a leading '-' in radix 10, exactly
// (VALUE_WIDTH+3)/4 two's-complement hex digits in radix 16, and the bare
// magnitude in other radices; the most negative value converts as its unsigned
// magnitude. Radix values above 16 act as 16, values below 2 act as 2. Only the
// low VALUE_WIDTH bits of value are used. Digits come out of a bit-serial
// divider, least significant first, one quotient bit per cycle; they are
// parked in a 64 x 4 RAM and read back in reverse. Each character then
// passes through the read, load and present steps and stays presented until
// the sink is ready; the '-' is presented directly. in_ch.ready is high only
// while no item is in flight.
module integer_to_radix_ascii #(
  parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  itoa_in_if.sink    in_ch,
  itoa_out_if.source out_ch
);
  import itoa_pkg::*;

  localparam int ADDR_W = $clog2(DIGIT_DEPTH);
  localparam int FIXED_DIGITS = (VALUE_WIDTH + 3) / 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_OUT
  } state_t;

  state_t              state_r, state_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0]   k_r, k_nxt;
  logic                fixed_r, fixed_nxt;
  logic                dash_r, dash_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;

  // Input decode
  logic [VALUE_WIDTH-1:0] in_val;
  logic [VALUE_WIDTH-1:0] in_mag;
  logic [RADIX_W-1:0]     in_radix;
  logic                   in_neg;
  logic                   in_hex;
  logic                   in_acc;

  div_ctl_t            div_ctl;
  div_sts_t            div_sts;
  logic                ram_we;
  logic [DIGIT_W-1:0]  ram_rdata;
  logic [COUNT_W-1:0]  count_inc;
  logic                stop;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_val = in_ch.value[VALUE_WIDTH-1:0];

  always_comb begin
    if (in_ch.radix > HEX_RADIX)      in_radix = HEX_RADIX;
    else if (in_ch.radix < MIN_RADIX) in_radix = MIN_RADIX;
    else                              in_radix = in_ch.radix;
    in_neg = in_ch.operation && in_val[VALUE_WIDTH-1];
    in_hex = (in_radix == HEX_RADIX);
    // Negative hex keeps the raw pattern; other negatives convert the magnitude.
    in_mag = (in_neg && !in_hex) ? (~in_val + 1'b1) : in_val;
  end

  itoa_divider #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .value (in_mag),
    .sts   (div_sts)
  );

  // Digits land at the collected count, LSD first.
  assign ram_we = (state_r == ST_DIVIDE) && div_sts.done;

  itoa_ram #(.WIDTH(DIGIT_W), .DEPTH(DIGIT_DEPTH)) u_digits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (div_sts.digit),
    .raddr (k_r),
    .rdata (ram_rdata)
  );

  assign count_inc = count_r + 1'b1;
  // Fixed-width hex stops on digit count, otherwise when the quotient runs out.
  assign stop = fixed_r ? (count_inc == COUNT_W'(FIXED_DIGITS)) : !div_sts.q_nz;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    fixed_nxt     = fixed_r;
    dash_nxt      = dash_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    div_ctl.start = 1'b0;
    div_ctl.load  = 1'b0;
    div_ctl.radix = in_radix;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          div_ctl.start = 1'b1;
          div_ctl.load  = 1'b1;
          count_nxt     = '0;
          fixed_nxt     = in_neg && in_hex;
          dash_nxt      = in_neg && (in_radix == DEC_RADIX);
          state_nxt     = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_sts.done) begin
          count_nxt = count_inc;
          if (stop) begin
            k_nxt = count_r[ADDR_W-1:0];  // index of the most significant digit
            if (dash_r) begin
              out_valid_nxt = 1'b1;
              out_char_nxt  = CHAR_MINUS;
              out_last_nxt  = 1'b0;
              state_nxt     = ST_EMIT_OUT;
            end else begin
              state_nxt = ST_EMIT_RD;
            end
          end else begin
            div_ctl.start = 1'b1;  // next pass on the quotient
          end
        end
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = digit_char(ram_rdata);
        out_last_nxt  = (k_r == '0);
        k_nxt         = k_r - 1'b1;
        state_nxt     = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (out_ch.ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = out_last_r ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      fixed_r     <= 1'b0;
      dash_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      fixed_r     <= fixed_nxt;
      dash_r      <= dash_nxt;
      out_valid_r <= out_valid_nxt;
    end
    k_r        <= k_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.character = out_char_r;
  assign out_ch.last      = out_last_r;

`ifndef SYNTHESIS
  a_busy_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken again before the string finished");
  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last) |=> in_ch.ready)
    else $error("not idle after the last character");
  a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == ST_DIVIDE))
    else $error("digit produced outside the divide phase");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (count_r < COUNT_W'(VALUE_WIDTH)))
    else $error("more digits than the value width allows");
`endif

endmodule

FILE: sv/itoa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module itoa_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/itoa_divider.sv
// Bit-serial divider by a small radix: one quotient bit per cycle, the
// remainder of each pass is one digit. Depends on itoa_pkg.
module itoa_divider #(
  parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  itoa_pkg::div_ctl_t           ctl,
  input  logic [VALUE_WIDTH-1:0]       value,
  output itoa_pkg::div_sts_t           sts
);
  import itoa_pkg::*;

  localparam int BIT_CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

  logic [VALUE_WIDTH-1:0] q_r, q_nxt;
  logic [RADIX_W-1:0]     radix_r;
  logic [RADIX_W-1:0]     rem_r, rem_nxt;
  logic [BIT_CNT_W-1:0]   bit_cnt_r;
  logic                   busy_r, done_r, q_nz_r;
  logic [RADIX_W-1:0]     trial;
  logic                   q_bit;

  // Shift the next dividend bit into the partial remainder; subtract if it fits.
  always_comb begin
    trial   = {rem_r[DIGIT_W-1:0], q_r[VALUE_WIDTH-1]};
    q_bit   = (trial >= radix_r);
    rem_nxt = q_bit ? (trial - radix_r) : trial;
    q_nxt   = {q_r[VALUE_WIDTH-2:0], q_bit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (bit_cnt_r == '0);
      if (ctl.start && !busy_r) begin
        busy_r <= 1'b1;
      end else if (busy_r && (bit_cnt_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
    if (ctl.start && !busy_r) begin
      bit_cnt_r <= BIT_CNT_W'(VALUE_WIDTH - 1);
      rem_r     <= '0;
      q_nz_r    <= 1'b0;
      if (ctl.load) begin
        q_r     <= value;
        radix_r <= ctl.radix;
      end
    end else if (busy_r) begin
      bit_cnt_r <= bit_cnt_r - 1'b1;
      rem_r     <= rem_nxt;
      q_r       <= q_nxt;
      q_nz_r    <= q_nz_r | q_bit;
    end
  end

  assign sts.done  = done_r;
  assign sts.q_nz  = q_nz_r;
  assign sts.digit = rem_r[DIGIT_W-1:0];

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !busy_r)
    else $error("divider started while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("digit done held for more than one cycle");
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < radix_r))
    else $error("digit not below radix");
`endif

endmodule
